/* sv/sfr_pkg.sv */
// Shared types, constants and helpers for the stream find-and-replace block.
// Used by sfr_cell and stream_find_replace; depends on nothing else.
package sfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 64;
  localparam int LEN_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPL_DEF    = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_REPL_BYTES     = 2'd2,
    REG_REPL_LENGTH    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_MARK,
    ST_DONE
  } state_t;

  // Broadcast control to every cell of the pending chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] byte_of(input logic [CFG_W-1:0] word,
                                                input logic [2:0] idx);
    return word[BYTE_W*idx +: BYTE_W];
  endfunction

endpackage

/* sv/sfr_cell.sv */
// One cell of the pending-byte chain: holds one byte, compares it with its
// pattern byte and takes its neighbor's byte on a shift. Depends on sfr_pkg.
module sfr_cell
  import sfr_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CW-1:0]     count,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [BYTE_W-1:0] neighbor,
  input  logic [BYTE_W-1:0] pattern_byte,
  output logic [BYTE_W-1:0] data,
  output logic              match
);

  always_ff @(posedge clk) begin
    if (ctrl.load && count == CW'(IDX)) begin
      data <= load_byte;
    end else if (ctrl.shift) begin
      data <= neighbor;
    end
  end

  assign match = (data == pattern_byte);

endmodule

/* sv/stream_find_replace.sv */
// Stream find-and-replace top level: configuration registers, sequencer,
// result staging and output register. Depends on sfr_pkg and sfr_cell.
//
// Usage: content bytes arrive on the input channel (in_valid/in_stall), one
// per transfer, with has_byte marking a real byte and stream_end closing the
// stream. Rewritten bytes leave on the output channel (out_valid/out_stall),
// one result per transfer; run_last flags the last result of an input item
// and end_marker the final result of the stream.
// Bytes that may still start a match sit in a chain of byte cells that shift
// toward cell 0 as held bytes are released.
// Throughput: one item at a time. An item causes up to nine results (eight
// bytes and the end marker), all on the single result path that releases one
// byte per cycle while the receiver does not stall. An item with neither byte
// nor end causes no result and leaves the sequencer idle.
// When the receiver stalls, the output register holds and the sequencer
// waits once its staging slot is full; nothing is lost.
// Reset: synchronous; clears the configuration registers, the held count and all valids.
// The user makes configuration writes through cfg_write/cfg_index/cfg_data while
// idle, unenforced by the block; pattern writes are ignored while bytes are held.
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = MAX_REPL_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 has_byte,
  input  logic                 stream_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 byte_valid,
  output logic                 run_last,
  output logic                 end_marker
);

  localparam int CW  = $clog2(MAX_PATTERN + 1);
  localparam int RCW = $clog2(MAX_REPLACEMENT + 1);

  // Configuration
  logic [CFG_W-1:0] pattern_bytes;
  logic [LEN_W-1:0] pattern_length;
  logic [CFG_W-1:0] replacement_bytes;
  logic [LEN_W-1:0] replacement_length;

  logic [CW-1:0]  plen;
  logic [RCW-1:0] rlen;

  // Sequencer state
  state_t         state, state_next;
  logic [CW-1:0]  count;
  logic [RCW-1:0] rcnt;
  logic           end_flag;

  // Staging slot and output register
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_bvalid;
  logic              stage_end;

  // Cell chain
  cell_ctrl_t        ctrl;
  logic [BYTE_W-1:0] cell_data [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_match;
  logic              prefix_ok;

  // Control from the output decode
  logic              accept;
  logic              out_free;
  logic              can_emit;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_bvalid;
  logic              emit_end;
  logic              push_last;
  logic              count_dec;
  logic              count_clr;
  logic              rcnt_inc;
  logic              rcnt_clr;

  assign plen = (pattern_length > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                       : CW'(pattern_length);
  assign rlen = (replacement_length > LEN_W'(MAX_REPLACEMENT)) ? RCW'(MAX_REPLACEMENT)
                                                               : RCW'(replacement_length);

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign can_emit = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_BYTES: begin
          if (count == '0) pattern_bytes <= cfg_data;
        end
        REG_PATTERN_LENGTH: begin
          if (count == '0) pattern_length <= cfg_data[LEN_W-1:0];
        end
        REG_REPL_BYTES: begin
          replacement_bytes <= cfg_data;
        end
        REG_REPL_LENGTH: begin
          replacement_length <= cfg_data[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pending chain: cell i takes cell i+1 on a shift, the last takes zero
  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic [BYTE_W-1:0] nb;
      if (gi == MAX_PATTERN - 1) begin : g_tail
        assign nb = '0;
      end else begin : g_mid
        assign nb = cell_data[gi+1];
      end
      sfr_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .count        (count),
        .load_byte    (in_byte),
        .neighbor     (nb),
        .pattern_byte (pattern_bytes[BYTE_W*gi +: BYTE_W]),
        .data         (cell_data[gi]),
        .match        (cell_match[gi])
      );
    end
  endgenerate

  // Held bytes still form a prefix of the pattern
  always_comb begin
    prefix_ok = (plen != '0);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CW'(i) < count && CW'(i) < plen && !cell_match[i]) prefix_ok = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (has_byte || stream_end)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (count == '0 || (prefix_ok && count < plen)) begin
          state_next = end_flag ? ST_FLUSH : ST_DONE;
        end else if (prefix_ok) begin
          state_next = ST_REPL;
        end
      end
      ST_REPL: begin
        if (rcnt == rlen) state_next = end_flag ? ST_FLUSH : ST_DONE;
      end
      ST_FLUSH: begin
        if (count == '0) state_next = ST_MARK;
      end
      ST_MARK: begin
        if (can_emit) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stage_valid || out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctrl        = '0;
    emit        = 1'b0;
    emit_byte   = cell_data[0];
    emit_bvalid = 1'b1;
    emit_end    = 1'b0;
    push_last   = 1'b0;
    count_dec   = 1'b0;
    count_clr   = 1'b0;
    rcnt_inc    = 1'b0;
    rcnt_clr    = 1'b0;
    case (state)
      ST_IDLE: begin
        ctrl.load = accept && has_byte;
      end
      ST_SCAN: begin
        rcnt_clr = 1'b1;
        if (count != '0 && !prefix_ok && can_emit) begin
          emit       = 1'b1;
          ctrl.shift = 1'b1;
          count_dec  = 1'b1;
        end
      end
      ST_REPL: begin
        if (rcnt == rlen) begin
          count_clr = 1'b1;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_byte = byte_of(replacement_bytes, 3'(rcnt));
          rcnt_inc  = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (count != '0 && can_emit) begin
          emit       = 1'b1;
          ctrl.shift = 1'b1;
          count_dec  = 1'b1;
        end
      end
      ST_MARK: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_byte   = '0;
          emit_bvalid = 1'b0;
          emit_end    = 1'b1;
        end
      end
      ST_DONE: begin
        push_last = stage_valid && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rcnt     <= '0;
      end_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) end_flag <= stream_end;
      if (ctrl.load && count < CW'(MAX_PATTERN)) begin
        count <= count + 1'b1;
      end else if (count_clr) begin
        count <= '0;
      end else if (count_dec) begin
        count <= count - 1'b1;
      end
      if (rcnt_clr) begin
        rcnt <= '0;
      end else if (rcnt_inc) begin
        rcnt <= rcnt + 1'b1;
      end
    end
  end

  // Staging slot: hold the newest result until its run_last is known
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (emit) begin
      stage_valid <= 1'b1;
    end else if (push_last) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stage_byte   <= emit_byte;
      stage_bvalid <= emit_bvalid;
      stage_end    <= emit_end;
    end
  end

  // Output register: advance the staged result on a new emit or at item end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((emit && stage_valid) || push_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit && stage_valid) || push_last) begin
      out_byte   <= stage_byte;
      byte_valid <= stage_bvalid;
      end_marker <= stage_end;
      run_last   <= push_last;
    end
  end

endmodule
